@@ hw/rtl/assert_macros.svh @@
// Assertion macros used by the top level of the pose velocity controller.
// Depends on a clock named clk and an active-low reset named rst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition must never hold outside reset.
`define ASSERT_NEVER(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

// Antecedent at one edge implies consequent at the next edge.
`define ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ hw/rtl/pdvc_pkg.sv @@
// Types and constants of the pose deflection velocity controller.
// No dependencies; used by the front, the back and the top level.
package pdvc_pkg;

    localparam logic [1:0] CMD_POSE   = 2'd0;
    localparam logic [1:0] CMD_TICK   = 2'd1;
    localparam logic [1:0] CMD_RZERO  = 2'd2;
    localparam logic [1:0] CMD_UNUSED = 2'd3;

    localparam logic [3:0] REG_GAIN_LINEAR     = 4'd0;
    localparam logic [3:0] REG_GAIN_YAW        = 4'd1;
    localparam logic [3:0] REG_LIMIT_LINEAR    = 4'd2;
    localparam logic [3:0] REG_LIMIT_YAW       = 4'd3;
    localparam logic [3:0] REG_FILTER_ALPHA    = 4'd4;
    localparam logic [3:0] REG_DEADBAND_LINEAR = 4'd5;
    localparam logic [3:0] REG_YAW_DEADBAND    = 4'd6;
    localparam logic [3:0] REG_MODE_FLAGS      = 4'd7;

    localparam int STALE_TIMEOUT_MS = 150;

    localparam logic signed [21:0] PI_Q16      = 22'sd205887;
    localparam logic signed [21:0] TWO_PI_Q16  = 22'sd411775;
    localparam logic signed [19:0] HALF_PI_Q16 = 20'sd102944;
    localparam logic signed [19:0] YAW_MAX     = 20'sd205887;

    localparam int CORDIC_STEPS = 16;
    localparam logic [16:0] ATAN_TAB [CORDIC_STEPS] = '{
        17'd51472, 17'd30386, 17'd16055, 17'd8150, 17'd4091, 17'd2047,
        17'd1024, 17'd512, 17'd256, 17'd128, 17'd64, 17'd32, 17'd16,
        17'd8, 17'd4, 17'd2
    };

    typedef struct packed {
        logic        [1:0]  command;
        logic signed [23:0] pos_x;
        logic signed [23:0] pos_y;
        logic signed [15:0] quat_w;
        logic signed [15:0] quat_x;
        logic signed [15:0] quat_y;
        logic signed [15:0] quat_z;
        logic        [31:0] time_ms;
    } item_t;

    typedef struct packed {
        logic signed [23:0] vel_x;
        logic signed [23:0] vel_y;
        logic signed [23:0] rate_yaw;
        logic               stale;
    } result_t;

    // Classified item handed from front to back.
    typedef struct packed {
        logic        [1:0]  kind;
        logic signed [23:0] pos_x;
        logic signed [23:0] pos_y;
        logic signed [19:0] yaw;
        logic        [31:0] time_ms;
    } job_t;

    typedef struct packed {
        logic [15:0] gain_linear;
        logic [15:0] gain_yaw;
        logic [22:0] limit_linear;
        logic [22:0] limit_yaw;
        logic [16:0] filter_alpha;
        logic [22:0] deadband_linear;
        logic [22:0] yaw_deadband;
        logic [1:0]  mode_flags;
    } cfg_t;

endpackage

@@ hw/rtl/pdvc_queue.sv @@
// Small register FIFO used between front and back and on the result side.
// Depends on nothing; payload is a plain vector.
module pdvc_queue #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             wr_en,
    input  logic [WIDTH-1:0] wdata,
    input  logic             rd_en,
    output logic [WIDTH-1:0] rdata,
    output logic             full,
    output logic             empty
);
    localparam int PW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [PW-1:0]    wr_ptr_reg;
    logic [PW-1:0]    rd_ptr_reg;
    logic [CW-1:0]    count_reg;
    logic             do_wr;
    logic             do_rd;

    assign full  = (count_reg == CW'(DEPTH));
    assign empty = (count_reg == '0);
    assign do_wr = wr_en && !full;
    assign do_rd = rd_en && !empty;
    assign rdata = mem_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            mem_reg[wr_ptr_reg] <= wdata;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_wr)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (do_rd)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (do_wr && !do_rd)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (do_rd && !do_wr)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end
endmodule

@@ hw/rtl/pdvc_front.sv @@
// Front end: accepts items, computes pose heading by iterative CORDIC, emits jobs.
// Depends on pdvc_pkg.
module pdvc_front import pdvc_pkg::*; (
    input  logic  clk,
    input  logic  rst_n,
    input  logic  push,
    input  item_t item,
    output logic  full,
    output logic  job_push,
    output job_t  job,
    input  logic  job_full
);
    typedef enum logic [2:0] {F_IDLE, F_PROD, F_ROT, F_ITER, F_PUSH} fstate_t;

    fstate_t            state_reg;
    item_t              item_reg;
    logic [2:0]         step_reg;
    logic signed [31:0] prod_reg;
    logic signed [33:0] num_reg;
    logic signed [33:0] den_reg;
    logic signed [35:0] cx_reg;
    logic signed [35:0] cy_reg;
    logic signed [19:0] cz_reg;
    logic               zero_reg;
    logic [3:0]         iter_reg;

    logic signed [15:0] ma;
    logic signed [15:0] mb;
    logic signed [31:0] prod;
    logic signed [35:0] x0;
    logic signed [35:0] y0;
    logic signed [35:0] sx;
    logic signed [35:0] sy;
    logic signed [19:0] tab;
    logic signed [19:0] yaw_clamped;

    assign full = (state_reg != F_IDLE);

    always_comb
    begin
        case (step_reg)
            3'd0:    begin ma = item_reg.quat_w; mb = item_reg.quat_z; end
            3'd1:    begin ma = item_reg.quat_x; mb = item_reg.quat_y; end
            3'd2:    begin ma = item_reg.quat_w; mb = item_reg.quat_w; end
            3'd3:    begin ma = item_reg.quat_x; mb = item_reg.quat_x; end
            3'd4:    begin ma = item_reg.quat_y; mb = item_reg.quat_y; end
            3'd5:    begin ma = item_reg.quat_z; mb = item_reg.quat_z; end
            default: begin ma = item_reg.quat_w; mb = item_reg.quat_z; end
        endcase
    end

    assign prod = ma * mb;
    assign x0   = 36'(den_reg);
    assign y0   = 36'(num_reg) <<< 1;
    assign sx   = cx_reg >>> iter_reg;
    assign sy   = cy_reg >>> iter_reg;
    assign tab  = signed'({3'b000, ATAN_TAB[iter_reg]});

    always_comb
    begin
        if (zero_reg)
        begin
            yaw_clamped = '0;
        end
        else if (cz_reg > YAW_MAX)
        begin
            yaw_clamped = YAW_MAX;
        end
        else if (cz_reg < -YAW_MAX)
        begin
            yaw_clamped = -YAW_MAX;
        end
        else
        begin
            yaw_clamped = cz_reg;
        end
    end

    assign job_push    = (state_reg == F_PUSH) && !job_full;
    assign job.kind    = item_reg.command;
    assign job.pos_x   = item_reg.pos_x;
    assign job.pos_y   = item_reg.pos_y;
    assign job.yaw     = yaw_clamped;
    assign job.time_ms = item_reg.time_ms;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= F_IDLE;
            step_reg  <= '0;
            iter_reg  <= '0;
            zero_reg  <= 1'b0;
        end
        else
        begin
            case (state_reg)
                F_IDLE:
                begin
                    if (push)
                    begin
                        item_reg <= item;
                        step_reg <= '0;
                        num_reg  <= '0;
                        den_reg  <= '0;
                        case (item.command)
                            CMD_POSE:  state_reg <= F_PROD;
                            CMD_TICK:  state_reg <= F_PUSH;
                            CMD_RZERO: state_reg <= F_PUSH;
                            default:   state_reg <= F_IDLE;
                        endcase
                    end
                end
                F_PROD:
                begin
                    // Multiply and register the product, folding the previous product in the same cycle.
                    prod_reg <= prod;
                    step_reg <= step_reg + 1'b1;
                    case (step_reg)
                        3'd1, 3'd2: num_reg <= num_reg + 34'(prod_reg);
                        3'd3, 3'd4: den_reg <= den_reg + 34'(prod_reg);
                        3'd5, 3'd6: den_reg <= den_reg - 34'(prod_reg);
                        default:    ;
                    endcase
                    if (step_reg == 3'd6)
                    begin
                        state_reg <= F_ROT;
                    end
                end
                F_ROT:
                begin
                    // Rotate left half plane into the right half by a quarter turn.
                    zero_reg <= (num_reg == '0) && (den_reg == '0);
                    iter_reg <= '0;
                    if (x0 < 0)
                    begin
                        if (y0 >= 0)
                        begin
                            cz_reg <= HALF_PI_Q16;
                            cx_reg <= y0;
                            cy_reg <= -x0;
                        end
                        else
                        begin
                            cz_reg <= -HALF_PI_Q16;
                            cx_reg <= -y0;
                            cy_reg <= x0;
                        end
                    end
                    else
                    begin
                        cz_reg <= '0;
                        cx_reg <= x0;
                        cy_reg <= y0;
                    end
                    state_reg <= F_ITER;
                end
                F_ITER:
                begin
                    if (cy_reg >= 0)
                    begin
                        cx_reg <= cx_reg + sy;
                        cy_reg <= cy_reg - sx;
                        cz_reg <= cz_reg + tab;
                    end
                    else
                    begin
                        cx_reg <= cx_reg - sy;
                        cy_reg <= cy_reg + sx;
                        cz_reg <= cz_reg - tab;
                    end
                    iter_reg <= iter_reg + 1'b1;
                    if (iter_reg == 4'(CORDIC_STEPS - 1))
                    begin
                        state_reg <= F_PUSH;
                    end
                end
                F_PUSH:
                begin
                    if (!job_full)
                    begin
                        state_reg <= F_IDLE;
                    end
                end
                default: state_reg <= F_IDLE;
            endcase
        end
    end
endmodule

@@ hw/rtl/pdvc_back.sv @@
// Back end: zero latch, deadbands, gains, clamps, low-pass filters and watchdog.
// Depends on pdvc_pkg; one shared multiplier sequenced over the pose work.
module pdvc_back import pdvc_pkg::*; (
    input  logic    clk,
    input  logic    rst_n,
    input  cfg_t    cfg,
    input  job_t    job,
    input  logic    job_empty,
    output logic    job_pop,
    output logic    res_push,
    output result_t res,
    input  logic    res_full
);
    typedef enum logic [1:0] {B_IDLE, B_RUN, B_EMIT} bstate_t;
    typedef enum logic [3:0] {
        OP_SQX, OP_SQY, OP_SQD, OP_GX, OP_GY, OP_GW,
        OP_FXA, OP_FXB, OP_FYA, OP_FYB, OP_FWA, OP_FWB
    } op_t;

    bstate_t            state_reg;
    op_t                op_reg;
    logic               ph_reg;
    logic               zl_reg;
    logic signed [23:0] zx_reg;
    logic signed [23:0] zy_reg;
    logic signed [19:0] zh_reg;
    logic [31:0]        lpt_reg;
    logic signed [23:0] fx_reg;
    logic signed [23:0] fy_reg;
    logic signed [23:0] fw_reg;
    logic               stale_reg;
    logic signed [24:0] ex_reg;
    logic signed [24:0] ey_reg;
    logic signed [19:0] ew_reg;
    logic signed [23:0] vx_reg;
    logic signed [23:0] vy_reg;
    logic signed [23:0] vw_reg;
    logic signed [51:0] prod_reg;
    logic signed [51:0] acc_reg;

    logic               latch_now;
    logic               zl_eff;
    logic signed [23:0] zx_eff;
    logic signed [23:0] zy_eff;
    logic signed [19:0] zh_eff;
    logic signed [24:0] ex_new;
    logic signed [24:0] ey_new;
    logic signed [21:0] dyaw;
    logic signed [21:0] wyaw;
    logic [21:0]        wabs;
    logic signed [19:0] ew_new;
    logic signed [32:0] tdiff;
    logic               stale_new;
    logic [16:0]        a_eff;
    logic [16:0]        a_inv;
    logic signed [25:0] ma;
    logic signed [25:0] mb;
    logic signed [51:0] prod;
    logic signed [51:0] lim;
    logic signed [51:0] gr;
    logic signed [23:0] gc;
    logic signed [51:0] fs;
    logic signed [23:0] fc;

    // Pose intake arithmetic on the queue head.
    assign latch_now = cfg.mode_flags[1] && !zl_reg;
    assign zl_eff    = zl_reg || latch_now;
    assign zx_eff    = latch_now ? job.pos_x : zx_reg;
    assign zy_eff    = latch_now ? job.pos_y : zy_reg;
    assign zh_eff    = latch_now ? job.yaw : zh_reg;
    assign ex_new    = 25'(job.pos_x) - (zl_eff ? 25'(zx_eff) : 25'sd0);
    assign ey_new    = 25'(job.pos_y) - (zl_eff ? 25'(zy_eff) : 25'sd0);
    assign dyaw      = 22'(job.yaw) - (zl_eff ? 22'(zh_eff) : 22'sd0);

    always_comb
    begin
        if (dyaw > PI_Q16)
        begin
            wyaw = dyaw - TWO_PI_Q16;
        end
        else if (dyaw < -PI_Q16)
        begin
            wyaw = dyaw + TWO_PI_Q16;
        end
        else
        begin
            wyaw = dyaw;
        end
        wabs   = (wyaw < 0) ? 22'(-wyaw) : 22'(wyaw);
        ew_new = ({1'b0, wabs} < {1'b0, cfg.yaw_deadband}) ? 20'sd0 : 20'(wyaw);
    end

    assign tdiff = signed'({1'b0, job.time_ms}) - signed'({1'b0, lpt_reg});
    assign stale_new = (STALE_TIMEOUT_MS > 0) &&
                       ((lpt_reg == '0) || (tdiff > 33'sd0 + 33'(STALE_TIMEOUT_MS)));

    assign a_eff = (cfg.filter_alpha > 17'd65536) ? 17'd65536 : cfg.filter_alpha;
    assign a_inv = 17'(18'd65536 - {1'b0, a_eff});

    always_comb
    begin
        case (op_reg)
            OP_SQX:  begin ma = 26'(ex_reg); mb = 26'(ex_reg); end
            OP_SQY:  begin ma = 26'(ey_reg); mb = 26'(ey_reg); end
            OP_SQD:  begin
                ma = signed'({3'b000, cfg.deadband_linear});
                mb = signed'({3'b000, cfg.deadband_linear});
            end
            OP_GX:   begin ma = 26'(ex_reg); mb = signed'({10'd0, cfg.gain_linear}); end
            OP_GY:   begin ma = 26'(ey_reg); mb = signed'({10'd0, cfg.gain_linear}); end
            OP_GW:   begin ma = 26'(ew_reg); mb = signed'({10'd0, cfg.gain_yaw}); end
            OP_FXA:  begin ma = signed'({9'd0, a_eff}); mb = 26'(vx_reg); end
            OP_FXB:  begin ma = signed'({9'd0, a_inv}); mb = 26'(fx_reg); end
            OP_FYA:  begin ma = signed'({9'd0, a_eff}); mb = 26'(vy_reg); end
            OP_FYB:  begin ma = signed'({9'd0, a_inv}); mb = 26'(fy_reg); end
            OP_FWA:  begin ma = signed'({9'd0, a_eff}); mb = 26'(vw_reg); end
            OP_FWB:  begin ma = signed'({9'd0, a_inv}); mb = 26'(fw_reg); end
            default: begin ma = '0; mb = '0; end
        endcase
    end

    assign prod = ma * mb;

    // Gain rounding and clamp on the registered product.
    assign lim = signed'({29'd0, (op_reg == OP_GW) ? cfg.limit_yaw : cfg.limit_linear});
    assign gr  = (prod_reg + 52'sd128) >>> 8;

    always_comb
    begin
        if (gr > lim)
        begin
            gc = 24'(lim);
        end
        else if (gr < -lim)
        begin
            gc = 24'(-lim);
        end
        else
        begin
            gc = 24'(gr);
        end
    end

    // Filter blend, round and saturate.
    assign fs = (acc_reg + prod_reg + 52'sd32768) >>> 16;

    always_comb
    begin
        if (fs > 52'sd8388607)
        begin
            fc = 24'sd8388607;
        end
        else if (fs < -52'sd8388608)
        begin
            fc = -24'sd8388608;
        end
        else
        begin
            fc = 24'(fs);
        end
    end

    assign job_pop      = (state_reg == B_IDLE) && !job_empty;
    assign res_push     = (state_reg == B_EMIT) && !res_full;
    assign res.vel_x    = fx_reg;
    assign res.vel_y    = fy_reg;
    assign res.rate_yaw = fw_reg;
    assign res.stale    = stale_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= B_IDLE;
            op_reg    <= OP_SQX;
            ph_reg    <= 1'b0;
            zl_reg    <= 1'b0;
            zx_reg    <= '0;
            zy_reg    <= '0;
            zh_reg    <= '0;
            lpt_reg   <= '0;
            fx_reg    <= '0;
            fy_reg    <= '0;
            fw_reg    <= '0;
            stale_reg <= 1'b0;
        end
        else
        begin
            case (state_reg)
                B_IDLE:
                begin
                    if (!job_empty)
                    begin
                        case (job.kind)
                            CMD_POSE:
                            begin
                                lpt_reg <= job.time_ms;
                                if (latch_now)
                                begin
                                    zl_reg <= 1'b1;
                                    zx_reg <= job.pos_x;
                                    zy_reg <= job.pos_y;
                                    zh_reg <= job.yaw;
                                end
                                ex_reg    <= ex_new;
                                ey_reg    <= ey_new;
                                ew_reg    <= ew_new;
                                op_reg    <= OP_SQX;
                                ph_reg    <= 1'b0;
                                state_reg <= B_RUN;
                            end
                            CMD_TICK:
                            begin
                                if (cfg.mode_flags[0])
                                begin
                                    stale_reg <= stale_new;
                                    if (stale_new)
                                    begin
                                        fx_reg <= '0;
                                        fy_reg <= '0;
                                        fw_reg <= '0;
                                    end
                                    state_reg <= B_EMIT;
                                end
                            end
                            CMD_RZERO: zl_reg <= 1'b0;
                            default:   ;
                        endcase
                    end
                end
                B_RUN:
                begin
                    if (!ph_reg)
                    begin
                        prod_reg <= prod;
                        ph_reg   <= 1'b1;
                    end
                    else
                    begin
                        ph_reg <= 1'b0;
                        op_reg <= op_t'(op_reg + 1'b1);
                        case (op_reg)
                            OP_SQX: acc_reg <= prod_reg;
                            OP_SQY: acc_reg <= acc_reg + prod_reg;
                            OP_SQD:
                            begin
                                // Radial deadband: drop both errors inside the circle.
                                if (acc_reg < prod_reg)
                                begin
                                    ex_reg <= '0;
                                    ey_reg <= '0;
                                end
                            end
                            OP_GX:  vx_reg <= gc;
                            OP_GY:  vy_reg <= gc;
                            OP_GW:  vw_reg <= gc;
                            OP_FXA: acc_reg <= prod_reg;
                            OP_FXB: fx_reg <= fc;
                            OP_FYA: acc_reg <= prod_reg;
                            OP_FYB: fy_reg <= fc;
                            OP_FWA: acc_reg <= prod_reg;
                            OP_FWB:
                            begin
                                fw_reg    <= fc;
                                state_reg <= B_IDLE;
                            end
                            default: state_reg <= B_IDLE;
                        endcase
                    end
                end
                B_EMIT:
                begin
                    if (!res_full)
                    begin
                        state_reg <= B_IDLE;
                    end
                end
                default: state_reg <= B_IDLE;
            endcase
        end
    end
endmodule

@@ hw/rtl/pose_deflection_velocity_controller.sv @@
// Pose deflection velocity controller: top level, config registers, queues.
// Depends on pdvc_pkg, pdvc_front, pdvc_back, pdvc_queue and assert_macros.svh.
//
// Usage:
//   Items enter through a queue-like port: drive item and push; a transfer
//   happens at a clock edge where push is high and full is low. Results leave
//   through a queue-like port: while empty is low the oldest result sits on
//   result; pop takes it. Only output ticks (with output enabled) give results.
//   A pose sample passes through the front as six quaternion products on one
//   16x16 multiplier, a quarter-turn pre-rotation and 16 CORDIC iterations,
//   and through the back as twelve products on one shared 26x26 multiplier.
//   Front and back overlap through the job queue, so the front can take a
//   new pose while the back still works on the previous one. A tick or
//   reset-zero skips the heading work in the front; a tick result passes
//   through the job queue and the back's emit state to the result queue.
//   Reset clears the zero latch, the last pose time and the filters and loads
//   the register defaults. When the receiver stalls, results pile up in the
//   result queue, then the back holds, then the job queue fills and full rises.
//   Configuration is written through cfg_we/cfg_index/cfg_data while no item
//   is in flight; indexes beyond the register list are dropped.
`include "assert_macros.svh"
module pose_deflection_velocity_controller import pdvc_pkg::*; #(
    parameter int JOB_DEPTH = 2,
    parameter int RES_DEPTH = 2
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    output logic        full,
    input  item_t       item,
    output logic        empty,
    input  logic        pop,
    output result_t     result,
    input  logic        cfg_we,
    input  logic [3:0]  cfg_index,
    input  logic [22:0] cfg_data
);
    cfg_t    cfg_reg;
    logic    job_push;
    job_t    job_in;
    job_t    job_out;
    logic    job_full;
    logic    job_empty;
    logic    job_pop;
    logic    res_push;
    result_t res_in;
    logic    res_full;

    // Register file: hold values until rewritten, drop unknown indexes.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.gain_linear     <= 16'd102;
            cfg_reg.gain_yaw        <= 16'd256;
            cfg_reg.limit_linear    <= 23'd32768;
            cfg_reg.limit_yaw       <= 23'd65536;
            cfg_reg.filter_alpha    <= 17'd26214;
            cfg_reg.deadband_linear <= 23'd655;
            cfg_reg.yaw_deadband    <= 23'd1311;
            cfg_reg.mode_flags      <= 2'd3;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_GAIN_LINEAR:     cfg_reg.gain_linear     <= cfg_data[15:0];
                REG_GAIN_YAW:        cfg_reg.gain_yaw        <= cfg_data[15:0];
                REG_LIMIT_LINEAR:    cfg_reg.limit_linear    <= cfg_data;
                REG_LIMIT_YAW:       cfg_reg.limit_yaw       <= cfg_data;
                REG_FILTER_ALPHA:    cfg_reg.filter_alpha    <= cfg_data[16:0];
                REG_DEADBAND_LINEAR: cfg_reg.deadband_linear <= cfg_data;
                REG_YAW_DEADBAND:    cfg_reg.yaw_deadband    <= cfg_data;
                REG_MODE_FLAGS:      cfg_reg.mode_flags      <= cfg_data[1:0];
                default:             ;
            endcase
        end
    end

    // Front: accept and classify, compute heading.
    pdvc_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .item     (item),
        .full     (full),
        .job_push (job_push),
        .job      (job_in),
        .job_full (job_full)
    );

    // Job queue decouples heading work from the control arithmetic.
    pdvc_queue #(
        .WIDTH ($bits(job_t)),
        .DEPTH (JOB_DEPTH)
    ) u_job_q (
        .clk   (clk),
        .rst_n (rst_n),
        .wr_en (job_push),
        .wdata (job_in),
        .rd_en (job_pop),
        .rdata (job_out),
        .full  (job_full),
        .empty (job_empty)
    );

    // Back: zero latch, deadbands, gain, clamp, filters, watchdog.
    pdvc_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .job       (job_out),
        .job_empty (job_empty),
        .job_pop   (job_pop),
        .res_push  (res_push),
        .res       (res_in),
        .res_full  (res_full)
    );

    // Result queue lets the back advance while the receiver stalls.
    pdvc_queue #(
        .WIDTH ($bits(result_t)),
        .DEPTH (RES_DEPTH)
    ) u_res_q (
        .clk   (clk),
        .rst_n (rst_n),
        .wr_en (res_push),
        .wdata (res_in),
        .rd_en (pop),
        .rdata (result),
        .full  (res_full),
        .empty (empty)
    );

    `ASSERT_NEVER(a_job_overflow, job_push && job_full, "job transfer into a full queue")
    `ASSERT_NEVER(a_res_overflow, res_push && res_full, "result transfer into a full queue")
    `ASSERT_NEXT(a_pose_busy, push && !full && (item.command == CMD_POSE), full,
                 "front took a pose but did not go busy")
endmodule
